// ===== rtl/slid_pkg.sv =====
package slid_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int POS_W      = 4;
    localparam int STAT_W     = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    // Result of the shared comparator: entry against operand.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

// ===== rtl/sorted_list_insert_delete_core.sv =====
// An insert scans entries, moves entries up from the top, writes the value and emits the list;
// a delete likewise scans, then moves entries down and emits the list. o_stall holds off a new
// request until the last result is loaded; one storage read port paces search and shift, and
// emission streams one element a cycle while the result channel is not stalled.
// Reset (synchronous, active low) empties the list and clears control; storage is not cleared.
module sorted_list_insert_delete_core
    import slid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic signed [WORD_W-1:0] i_value,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [WORD_W-1:0] o_element,
    output logic [POS_W-1:0]         o_position,
    output logic                     o_list_empty,
    output logic                     o_last
);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SR_RD  = 6'b000010,   // issue search read
        S_SR_CMP = 6'b000100,   // compare fetched entry
        S_SH_RD  = 6'b001000,   // issue shift read or finish
        S_SH_WR  = 6'b010000,   // write moved entry
        S_EMIT   = 6'b100000    // stream list out
    } t_state;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_word   r_val, n_val;
    t_cnt    r_count, n_count;
    t_cnt    r_ptr, n_ptr;      // search / shift destination / emit read index
    t_cnt    r_pos, n_pos;      // insert slot
    t_cnt    r_eptr, n_eptr;    // index of next element loaded to output
    logic    r_pend, n_pend;    // emit read in flight, data in storage read register
    t_status r_status, n_status;

    logic    r_o_valid, n_o_valid;
    t_status r_o_status, n_o_status;
    t_word   r_o_element, n_o_element;
    t_cnt    r_o_pos, n_o_pos;
    logic    r_o_empty, n_o_empty;
    logic    r_o_last, n_o_last;

    // storage port controls
    logic    mem_wr_en;
    t_idx    mem_wr_addr;
    t_word   mem_wr_data;
    logic    mem_rd_en;
    t_idx    mem_rd_addr;
    t_word   mem_rd_data;
    t_cmp    cmp;

    logic    out_free;
    logic    emit_load;
    logic    emit_issue;
    logic    emit_last;
    t_cnt    ptr_inc;
    t_cnt    ptr_dec;

    slid_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // One comparator serves both the insert walk and the delete match.
    slid_cmp u_cmp (
        .i_entry   (mem_rd_data),
        .i_operand (r_val),
        .o_cmp     (cmp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign ptr_inc  = r_ptr + 1'b1;
    assign ptr_dec  = r_ptr - 1'b1;

    // Emit pipeline: a read is registered in the storage read register,
    // then moves into the output register once that register is free.
    assign emit_load  = (r_state == S_EMIT) && r_pend && out_free;
    assign emit_issue = (r_state == S_EMIT) && (r_count != '0) && (r_ptr != r_count)
                        && (!r_pend || emit_load);
    assign emit_last  = (t_cnt'(r_eptr + 1'b1) == r_count);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_eptr      = r_eptr;
        n_pend      = r_pend;
        n_status    = r_status;
        n_o_valid   = r_o_valid && i_stall;
        n_o_status  = r_o_status;
        n_o_element = r_o_element;
        n_o_pos     = r_o_pos;
        n_o_empty   = r_o_empty;
        n_o_last    = r_o_last;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_ptr[IDX_W-1:0];
        mem_wr_data = r_val;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_ptr[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = t_op'(i_operation);
                    n_val  = i_value;
                    n_ptr  = '0;
                    n_eptr = '0;
                    n_pend = 1'b0;
                    if (t_op'(i_operation) == OP_INSERT && r_count == t_cnt'(LIST_DEPTH)) begin
                        // refuse insert into a full list
                        n_status = STAT_FULL;
                        n_state  = S_EMIT;
                    end else if (t_op'(i_operation) == OP_DELETE && r_count == '0) begin
                        n_status = STAT_EMPTY;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SR_RD;
                    end
                end
            end

            S_SR_RD: begin
                if (r_ptr == r_count) begin
                    // walked off the end
                    if (r_op == OP_INSERT) begin
                        n_pos   = r_ptr;
                        n_state = S_SH_RD;
                    end else begin
                        n_status = STAT_NOT_FOUND;
                        n_ptr    = '0;
                        n_state  = S_EMIT;
                    end
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_ptr[IDX_W-1:0];
                    n_state     = S_SR_CMP;
                end
            end

            S_SR_CMP: begin
                if (r_op == OP_INSERT) begin
                    if (cmp.lt) begin
                        n_ptr   = ptr_inc;
                        n_state = S_SR_RD;
                    end else begin
                        // slot found; move entries up starting from the top
                        n_pos   = r_ptr;
                        n_ptr   = r_count;
                        n_state = S_SH_RD;
                    end
                end else begin
                    if (cmp.eq) begin
                        n_state = S_SH_RD;
                    end else begin
                        n_ptr   = ptr_inc;
                        n_state = S_SR_RD;
                    end
                end
            end

            S_SH_RD: begin
                if (r_op == OP_INSERT) begin
                    if (r_ptr == r_pos) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_pos[IDX_W-1:0];
                        mem_wr_data = r_val;
                        n_count     = r_count + 1'b1;
                        n_status    = STAT_OK;
                        n_ptr       = '0;
                        n_state     = S_EMIT;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ptr_dec[IDX_W-1:0];
                        n_state     = S_SH_WR;
                    end
                end else begin
                    if (ptr_inc >= r_count) begin
                        n_count  = r_count - 1'b1;
                        n_status = STAT_OK;
                        n_ptr    = '0;
                        n_state  = S_EMIT;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ptr_inc[IDX_W-1:0];
                        n_state     = S_SH_WR;
                    end
                end
            end

            S_SH_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_ptr[IDX_W-1:0];
                mem_wr_data = mem_rd_data;
                n_ptr       = (r_op == OP_INSERT) ? ptr_dec : ptr_inc;
                n_state     = S_SH_RD;
            end

            S_EMIT: begin
                if (r_count == '0) begin
                    // one result flagged empty
                    if (out_free) begin
                        n_o_valid   = 1'b1;
                        n_o_status  = r_status;
                        n_o_element = '0;
                        n_o_pos     = '0;
                        n_o_empty   = 1'b1;
                        n_o_last    = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    if (emit_issue) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_ptr[IDX_W-1:0];
                        n_ptr       = ptr_inc;
                    end
                    if (emit_load) begin
                        n_o_valid   = 1'b1;
                        n_o_status  = r_status;
                        n_o_element = mem_rd_data;
                        n_o_pos     = r_eptr;
                        n_o_empty   = 1'b0;
                        n_o_last    = emit_last;
                        n_eptr      = t_cnt'(r_eptr + 1'b1);
                        if (emit_last) begin
                            n_state = S_IDLE;
                        end
                    end
                    n_pend = emit_issue || (r_pend && !emit_load);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_pos       <= n_pos;
        r_eptr      <= n_eptr;
        r_status    <= n_status;
        r_o_status  <= n_o_status;
        r_o_element <= n_o_element;
        r_o_pos     <= n_o_pos;
        r_o_empty   <= n_o_empty;
        r_o_last    <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_element    = r_o_element;
    assign o_position   = POS_W'(r_o_pos);
    assign o_list_empty = r_o_empty;
    assign o_last       = r_o_last;

    // The list never grows past its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(LIST_DEPTH))
        else $error("entry count exceeds list depth");

    // An emit read is only ever in flight while streaming.
    a_pend_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_EMIT))
        else $error("emit read pending outside emit");

    // A completed insert adds exactly one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD && r_op == OP_INSERT && r_ptr == r_pos)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list by one");

    // The search index never passes the fill level.
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_RD || r_state == S_SR_CMP) |-> (r_ptr <= r_count))
        else $error("search index beyond list fill");

    // Every result loaded while streaming the list carries a position inside it.
    a_emit_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |-> (r_eptr < r_count))
        else $error("emitted position beyond list fill");

endmodule

// ===== rtl/slid_mem.sv =====
module slid_mem
    import slid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_wr_en,
    input  t_idx  i_wr_addr,
    input  t_word i_wr_data,
    input  logic  i_rd_en,
    input  t_idx  i_rd_addr,
    output t_word o_rd_data
);

    t_word r_mem [LIST_DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/slid_cmp.sv =====
module slid_cmp
    import slid_pkg::*;
(
    input  t_word i_entry,
    input  t_word i_operand,
    output t_cmp  o_cmp
);

    always_comb begin
        o_cmp.lt = (i_entry < i_operand);
        o_cmp.eq = (i_entry == i_operand);
    end

endmodule
